[rtl/ffha_pkg.sv]
// ffha_pkg: shared codes and constants for the first-fit heap allocator.
// No dependencies; used by every other file of the block but ffha_table.
package ffha_pkg;

    localparam int unsigned ALIGN_BYTES = 16;
    localparam int unsigned REQ_W       = 11;
    localparam int unsigned OFS_W       = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ALU_SUB  = 2'd0,
        ALU_ADDH = 2'd1,
        ALU_SUBH = 2'd2
    } t_alu_op;

endpackage

[rtl/ffha_if.sv]
// ffha_req_if / ffha_rsp_if: valid-ready channels of the allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [ffha_pkg::REQ_W-1:0]   request_bytes;
    logic [ffha_pkg::OFS_W-1:0]   free_offset;
    modport source (output valid, operation, request_bytes, free_offset, input ready);
    modport sink   (input valid, operation, request_bytes, free_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [ffha_pkg::OFS_W-1:0]   payload_offset;
    modport source (output valid, status, payload_offset, input ready);
    modport sink   (input valid, status, payload_offset, output ready);
endinterface

[rtl/ffha_alu.sv]
// ffha_alu: shared add/subtract/compare unit used by the sequencer steps.
// Depends on ffha_pkg.
module ffha_alu #(
    parameter int unsigned W   = 13,
    parameter int unsigned HDR = 32
) (
    input  ffha_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_res,
    output logic              o_ge
);
    import ffha_pkg::*;

    logic [W:0] diff;

    always_comb begin
        diff = {1'b0, i_a} - {1'b0, i_b};
        o_ge = ~diff[W];
        case (i_op)
            ALU_SUB:  o_res = diff[W-1:0];
            ALU_ADDH: o_res = i_a + i_b + W'(HDR);
            ALU_SUBH: o_res = diff[W-1:0] - W'(HDR);
            default:  o_res = diff[W-1:0];
        endcase
    end
endmodule

[rtl/ffha_table.sv]
// ffha_table: block table memory, one write port and one registered read port.
// Depends on no other file; it does not use ffha_pkg.
module ffha_table #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned EW    = 23
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [EW-1:0]            i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [EW-1:0]            o_rd_data
);
    logic [EW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end
endmodule

[rtl/first_fit_heap_allocator_unit.sv]
// first_fit_heap_allocator_unit: top level, sequencer over the block table.
// Depends on ffha_pkg, ffha_if, ffha_alu and ffha_table.
//
//   channel  dir  transaction fields
//   i_req    in   operation, request_bytes, free_offset
//   o_rsp    out  status, payload_offset
//
// One transaction at a time. The table walk visits one entry at a time through
// the single registered table read port, and each entry moved on split or merge
// takes a read and a write of the table.
// Reset loads entry 0 with the whole heap in the reset cycle.
// A waiting result holds in the output register while the next request is taken.
module first_fit_heap_allocator_unit #(
    parameter int unsigned HEAP_BYTES   = 1024,
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned MAX_BLOCKS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);
    import ffha_pkg::*;

    localparam int unsigned SW = $clog2(HEAP_BYTES + 1);
    localparam int unsigned AW = ((SW > 12) ? SW : 12) + 1;
    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned EW = 2 * SW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_AFIT   = 4'd3;
    localparam logic [3:0] S_ASTART = 4'd4;
    localparam logic [3:0] S_ASIZE  = 4'd5;
    localparam logic [3:0] S_AUSE   = 4'd6;
    localparam logic [3:0] S_FMP    = 4'd7;
    localparam logic [3:0] S_FNRD   = 4'd8;
    localparam logic [3:0] S_FNCHK  = 4'd9;
    localparam logic [3:0] S_FWR    = 4'd10;
    localparam logic [3:0] S_SHRD   = 4'd11;
    localparam logic [3:0] S_SHWR   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [SW-1:0] size;
        logic          used;
    } t_entry;

    logic [3:0]    r_state, n_state, r_ret, n_ret;
    logic          r_op, n_op;
    logic [AW-1:0] r_need, n_need, r_split, n_split, r_key, n_key;
    logic          r_key_ok, n_key_ok;
    logic [IW-1:0] r_idx, n_idx, r_k, n_k, r_lim, n_lim;
    logic          r_up, n_up;
    logic [CW-1:0] r_count, n_count;
    t_entry        r_cur, n_cur, r_prev, n_prev;
    logic          r_prev_ok, n_prev_ok;
    logic          r_res_st, n_res_st;
    logic [OFS_W-1:0] r_res_ofs, n_res_ofs;
    logic          r_out_valid, n_out_valid;
    logic          r_status, n_status;
    logic [OFS_W-1:0] r_offset, n_offset;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    t_entry        wr_data, rd_data;
    logic [EW-1:0] rd_raw;

    t_alu_op       alu_op;
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_ge;
    logic          accept;

    ffha_table #(.DEPTH(MAX_BLOCKS), .EW(EW)) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_raw)
    );
    assign rd_data = rd_raw;

    ffha_alu #(.W(AW), .HDR(HEADER_BYTES)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_res(alu_res),
        .o_ge (alu_ge)
    );

    assign i_req.ready          = (r_state == S_IDLE);
    assign accept               = i_req.valid && i_req.ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.payload_offset = r_offset;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_op = r_op;
        n_need = r_need;  n_split = r_split;  n_key = r_key;  n_key_ok = r_key_ok;
        n_idx = r_idx;  n_k = r_k;  n_lim = r_lim;  n_up = r_up;  n_count = r_count;
        n_cur = r_cur;  n_prev = r_prev;  n_prev_ok = r_prev_ok;
        n_res_st = r_res_st;  n_res_ofs = r_res_ofs;
        n_out_valid = r_out_valid;  n_status = r_status;  n_offset = r_offset;
        wr_en = 1'b0;  wr_addr = r_idx;  wr_data = r_cur;
        rd_addr = r_idx;
        alu_op = ALU_SUB;  alu_a = '0;  alu_b = '0;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_req.operation;
                    n_need    = (AW'(i_req.request_bytes) + AW'(ALIGN_BYTES - 1))
                                & ~AW'(ALIGN_BYTES - 1);
                    n_split   = n_need + AW'(HEADER_BYTES + ALIGN_BYTES);
                    n_key     = AW'(i_req.free_offset) - AW'(HEADER_BYTES);
                    n_key_ok  = (AW'(i_req.free_offset) >= AW'(HEADER_BYTES));
                    n_idx     = '0;
                    n_prev_ok = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                alu_a = AW'(rd_data.size);
                alu_b = r_need;
                if ((r_op == OP_ALLOC) ? (!rd_data.used && alu_ge)
                                       : (r_key_ok && AW'(rd_data.start) == r_key)) begin
                    n_cur   = rd_data;
                    n_state = (r_op == OP_ALLOC) ? S_AFIT : S_FMP;
                end else begin
                    n_prev    = rd_data;
                    n_prev_ok = 1'b1;
                    if (CW'(r_idx) + CW'(1) == r_count) begin
                        n_res_st  = ST_FAIL;
                        n_res_ofs = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_AFIT: begin
                alu_a = AW'(r_cur.size);
                alu_b = r_split;
                if (alu_ge && r_count < CW'(MAX_BLOCKS)) begin
                    n_k     = IW'(r_count);
                    n_lim   = r_idx + IW'(1);
                    n_up    = 1'b1;
                    n_ret   = S_ASTART;
                    n_state = S_SHRD;
                end else begin
                    n_state = S_AUSE;
                end
            end
            S_ASTART: begin
                alu_op  = ALU_ADDH;
                alu_a   = AW'(r_cur.start);
                alu_b   = r_need;
                n_prev.start = alu_res[SW-1:0];
                n_state = S_ASIZE;
            end
            S_ASIZE: begin
                alu_op  = ALU_SUBH;
                alu_a   = AW'(r_cur.size);
                alu_b   = r_need;
                wr_en   = 1'b1;
                wr_addr = r_idx + IW'(1);
                wr_data = '{start: r_prev.start, size: alu_res[SW-1:0], used: 1'b0};
                n_cur.size = r_need[SW-1:0];
                n_state = S_AUSE;
            end
            S_AUSE: begin
                alu_op  = ALU_ADDH;
                alu_a   = AW'(r_cur.start);
                wr_en   = 1'b1;
                wr_data = '{start: r_cur.start, size: r_cur.size, used: 1'b1};
                n_res_st  = ST_OK;
                n_res_ofs = alu_res[OFS_W-1:0];
                n_state   = S_DONE;
            end
            S_FMP: begin
                n_cur.used = 1'b0;
                alu_op = ALU_ADDH;
                alu_a  = AW'(r_prev.size);
                alu_b  = AW'(r_cur.size);
                if (r_prev_ok && !r_prev.used) begin
                    n_cur   = '{start: r_prev.start, size: alu_res[SW-1:0], used: 1'b0};
                    n_idx   = r_idx - IW'(1);
                    n_k     = r_idx;
                    n_lim   = IW'(r_count - CW'(1));
                    n_up    = 1'b0;
                    n_ret   = S_FNRD;
                    n_state = S_SHRD;
                end else begin
                    n_state = S_FNRD;
                end
            end
            S_FNRD: begin
                rd_addr = r_idx + IW'(1);
                n_state = (CW'(r_idx) + CW'(1) < r_count) ? S_FNCHK : S_FWR;
            end
            S_FNCHK: begin
                alu_op = ALU_ADDH;
                alu_a  = AW'(r_cur.size);
                alu_b  = AW'(rd_data.size);
                if (!rd_data.used) begin
                    n_cur.size = alu_res[SW-1:0];
                    n_k     = r_idx + IW'(1);
                    n_lim   = IW'(r_count - CW'(1));
                    n_up    = 1'b0;
                    n_ret   = S_FWR;
                    n_state = S_SHRD;
                end else begin
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                wr_en     = 1'b1;
                n_res_st  = ST_OK;
                n_res_ofs = '0;
                n_state   = S_DONE;
            end
            S_SHRD: begin
                rd_addr = r_up ? (r_k - IW'(1)) : (r_k + IW'(1));
                if (r_k == r_lim) begin
                    n_count = r_up ? (r_count + CW'(1)) : (r_count - CW'(1));
                    n_state = r_ret;
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = rd_data;
                n_k     = r_up ? (r_k - IW'(1)) : (r_k + IW'(1));
                n_state = S_SHRD;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_st;
                    n_offset    = r_res_ofs;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (!i_rst_n) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{start: '0, size: SW'(HEAP_BYTES - HEADER_BYTES), used: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ret <= n_ret;  r_op <= n_op;
        r_need <= n_need;  r_split <= n_split;  r_key <= n_key;  r_key_ok <= n_key_ok;
        r_idx <= n_idx;  r_k <= n_k;  r_lim <= n_lim;  r_up <= n_up;
        r_cur <= n_cur;  r_prev <= n_prev;  r_prev_ok <= n_prev_ok;
        r_res_st <= n_res_st;  r_res_ofs <= n_res_ofs;
        r_status <= n_status;  r_offset <= n_offset;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while busy");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !wr_en)
        else $error("table write outside a transaction");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SHRD) |=> $stable(r_count))
        else $error("block count changed outside a shift");
`endif
endmodule

[test/ffha_checker.sv]
// ffha_checker: watches the allocator's request and result channels, keeps a
// copy of the block table, predicts each result and compares it. Depends on ffha_pkg.
module ffha_checker #(
    parameter int unsigned HEAP_BYTES   = 1024,
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned MAX_BLOCKS   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic                         i_operation,
    input  logic [ffha_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [ffha_pkg::OFS_W-1:0]   i_free_offset,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic                         i_status,
    input  logic [ffha_pkg::OFS_W-1:0]   i_payload_offset,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    typedef struct packed {
        logic               status;
        logic [OFS_W-1:0]   payload_offset;
    } t_result;

    int unsigned blk_start [MAX_BLOCKS];
    int unsigned blk_size  [MAX_BLOCKS];
    bit          blk_used  [MAX_BLOCKS];
    int unsigned blk_count;
    t_result     expected_results[$];

    assign o_pending = expected_results.size();

    function automatic void table_reset();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            blk_start[k] = 0;
            blk_size[k]  = 0;
            blk_used[k]  = 0;
        end
        blk_size[0] = HEAP_BYTES - HEADER_BYTES;
        blk_count   = 1;
    endfunction

    function automatic void remove_entry(int unsigned pos);
        for (int unsigned k = pos; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k]  = blk_size[k+1];
            blk_used[k]  = blk_used[k+1];
        end
        blk_count--;
    endfunction

    function automatic t_result heap_predict(logic op, int unsigned req, int unsigned ofs);
        t_result     r;
        int unsigned need;
        int unsigned i;
        r.status = ST_FAIL;
        r.payload_offset = '0;
        if (op == OP_ALLOC) begin
            need = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
            for (i = 0; i < blk_count; i++)
                if (!blk_used[i] && blk_size[i] >= need) break;
            if (i < blk_count) begin
                blk_used[i] = 1;
                if (blk_size[i] >= need + HEADER_BYTES + ALIGN_BYTES
                        && blk_count < MAX_BLOCKS) begin
                    for (int unsigned k = blk_count; k > i + 1; k--) begin
                        blk_start[k] = blk_start[k-1];
                        blk_size[k]  = blk_size[k-1];
                        blk_used[k]  = blk_used[k-1];
                    end
                    blk_count++;
                    blk_start[i+1] = blk_start[i] + HEADER_BYTES + need;
                    blk_size[i+1]  = blk_size[i] - need - HEADER_BYTES;
                    blk_used[i+1]  = 0;
                    blk_size[i]    = need;
                end
                r.status = ST_OK;
                r.payload_offset = OFS_W'(blk_start[i] + HEADER_BYTES);
            end
        end else begin
            for (i = 0; i < blk_count; i++)
                if (blk_start[i] + HEADER_BYTES == ofs) break;
            if (i < blk_count) begin
                blk_used[i] = 0;
                if (i > 0 && !blk_used[i-1]) begin
                    blk_size[i-1] += blk_size[i] + HEADER_BYTES;
                    remove_entry(i);
                    i--;
                end
                if (i + 1 < blk_count && !blk_used[i+1]) begin
                    blk_size[i] += blk_size[i+1] + HEADER_BYTES;
                    remove_entry(i + 1);
                end
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            table_reset();
            expected_results.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                expected_results.push_back(heap_predict(i_operation,
                    i_request_bytes, i_free_offset));
            if (i_rsp_valid && i_rsp_ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result status=%0d payload_offset=%0d",
                        i_status, i_payload_offset);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.status !== i_status) begin
                        $error("status: expected %0d, got %0d", e.status, i_status);
                        o_fail_count <= o_fail_count + 1;
                    end else if (e.payload_offset !== i_payload_offset) begin
                        $error("payload_offset: expected %0d, got %0d",
                            e.payload_offset, i_payload_offset);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    initial table_reset();
endmodule

[test/tb.sv]
// tb: stimulus and verdict for first_fit_heap_allocator_unit.
// Depends on ffha_pkg, ffha_if, the block and ffha_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   cycle_count = 0;
    int   fail_count, pending, result_count;
    int   sent_count = 0;
    bit   sink_hold = 0;
    int unsigned live_offsets[$];

    ffha_req_if req_ch();
    ffha_rsp_if rsp_ch();

    first_fit_heap_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    ffha_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_ch.valid), .i_req_ready(req_ch.ready),
        .i_operation(req_ch.operation), .i_request_bytes(req_ch.request_bytes),
        .i_free_offset(req_ch.free_offset),
        .i_rsp_valid(rsp_ch.valid), .i_rsp_ready(rsp_ch.ready),
        .i_status(rsp_ch.status), .i_payload_offset(rsp_ch.payload_offset),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 0;
        req_ch.operation = OP_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.free_offset = '0;
        rsp_ch.ready = 0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // keep offsets handed out, so frees mostly hit live blocks
    always @(posedge i_clk)
        if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK
                && rsp_ch.payload_offset != 0)
            live_offsets.push_back(rsp_ch.payload_offset);

    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (sink_hold) begin
                rsp_ch.ready <= 0;
                @(posedge i_clk);
            end else begin
                g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                if (g > 0) begin
                    rsp_ch.ready <= 0;
                    repeat (g) @(posedge i_clk);
                end
                rsp_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send(logic op, int unsigned req, int unsigned ofs);
        int g;
        g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (g > 0) begin
            req_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.operation <= op;
        req_ch.request_bytes <= REQ_W'(req);
        req_ch.free_offset <= OFS_W'(ofs);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned pick, idx;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send(OP_ALLOC, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                : $urandom_range(0, 120), $urandom);
        else if (pick < 88 && live_offsets.size() > 0) begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            send(OP_FREE, $urandom, live_offsets[idx]);
            live_offsets.delete(idx);
        end else
            send(OP_FREE, $urandom, $urandom_range(0, 1023));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 1, 1023);
        send(OP_ALLOC, 16, 0);
        send(OP_ALLOC, 17, 0);
        send(OP_ALLOC, 2047, 0);
        send(OP_ALLOC, 1024, 0);
        send(OP_FREE, 0, 32);
        send(OP_FREE, 0, 32);
        send(OP_FREE, 2047, 1023);
        send(OP_FREE, 0, 0);
        send(OP_FREE, 0, 96);
        send(OP_FREE, 0, 80);
        send(OP_ALLOC, 992, 0);
        send(OP_ALLOC, 0, 0);
        send(OP_FREE, 0, 32);
        drain();
        live_offsets.delete();
        // fill the heap with tiny blocks until it is full
        for (int k = 0; k < 34; k++) send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 1, 0);
        drain();
        for (int k = 0; k < 450; k++) send_random();
        drain();
        sink_hold = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                sink_hold = 0;
            end
            for (int k = 0; k < 20; k++) send_random();
        join
        for (int k = 0; k < 500; k++) send_random();
        drain();
        $display("sent %0d transactions, checked %0d results: allocs, frees, splits,",
            sent_count, result_count);
        $display("merges, full table, unmatched and double frees, receiver stalls");
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
